>>> rtl/wdrc_pkg.sv
// Wildcard digit residue counter: shared constants, types and constant tables.
// Used by every module in rtl/. No dependencies.

package wdrc_pkg;

    localparam int RESIDUE_MODULUS = 13;
    localparam int RIDX_W          = $clog2(RESIDUE_MODULUS);
    localparam int CNT_W           = 30;
    localparam int SUM_W           = CNT_W + 2;
    localparam int DIGIT_W         = 4;
    localparam int TGT_W           = 4;
    localparam int DIGIT_BASE      = 10;
    localparam int WILD_DIGITS     = 10;

    localparam logic [CNT_W-1:0] COUNT_MOD    = CNT_W'(1000000007);
    localparam logic [TGT_W-1:0] TARGET_RESET = TGT_W'(5);

    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [RIDX_W-1:0] ridx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALIGN,
        ST_ACCUM,
        ST_SLIDE,
        ST_COMMIT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic rotate;
        logic acc_en;
        logic use_tap;
        logic push;
        logic commit;
        logic emit;
        logic wild;
    } ctl_t;

    // Remainder j whose image 10*j mod M is s.
    function automatic ridx_t j_of_s(input int s);
        int    j;
        ridx_t r;
        r = '0;
        for (j = 0; j < RESIDUE_MODULUS; j++)
        begin
            if (((j * DIGIT_BASE) % RESIDUE_MODULUS) == s)
                r = ridx_t'(j);
        end
        return r;
    endfunction

    // Index of (r - start) modulo M.
    function automatic ridx_t rot_src(input int r, input int start);
        return ridx_t'((r - start + RESIDUE_MODULUS) % RESIDUE_MODULUS);
    endfunction

    // Digit value reduced modulo M; digit values stay below twice M.
    function automatic ridx_t digit_residue(input logic [DIGIT_W-1:0] dg);
        int v;
        v = int'(dg);
        if (v >= RESIDUE_MODULUS)
            v = v - RESIDUE_MODULUS;
        return ridx_t'(v);
    endfunction

endpackage

>>> rtl/wdrc_mod_unit.sv
// Shared modular unit: y = (a + b - c) mod COUNT_MOD, all operands reduced.
// Depends on wdrc_pkg.

module wdrc_mod_unit
    import wdrc_pkg::*;
(
    input  cnt_t a,
    input  cnt_t b,
    input  cnt_t c,
    output cnt_t y
);

    localparam logic [SUM_W-1:0] MOD_X  = SUM_W'(COUNT_MOD);
    localparam logic [SUM_W-1:0] MOD_X2 = SUM_W'(COUNT_MOD) << 1;

    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] red;

    // a + b + (P - c) lies below 3P
    assign sum = SUM_W'(a) + SUM_W'(b) + (MOD_X - SUM_W'(c));

    always_comb
    begin
        if (sum >= MOD_X2)
            red = sum - MOD_X2;
        else if (sum >= MOD_X)
            red = sum - MOD_X;
        else
            red = sum;
    end

    assign y = red[CNT_W-1:0];

endmodule

>>> rtl/wdrc_ctrl.sv
// Sequencer for the residue counter: align, window accumulate, slide, commit, emit.
// Depends on wdrc_pkg.

module wdrc_ctrl
    import wdrc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               kind,
    input  logic [DIGIT_W-1:0] digit,
    input  logic               out_free,
    output logic               in_ready,
    output ctl_t               ctl
);

    state_t state_reg, state_next;
    ridx_t  step_reg,  step_next;
    ridx_t  align_reg, align_next;
    logic   kind_reg,  kind_next;

    ridx_t  d_mod;
    ridx_t  align_init;
    ridx_t  win_last;
    logic   accept;

    assign in_ready   = (state_reg == ST_IDLE);
    assign accept     = in_valid && in_ready;
    assign d_mod      = digit_residue(digit);
    assign align_init = (d_mod == '0) ? '0 : ridx_t'(RESIDUE_MODULUS - int'(d_mod));
    assign win_last   = kind_reg ? ridx_t'(WILD_DIGITS - 1) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            align_reg <= '0;
            kind_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            align_reg <= align_next;
            kind_reg  <= kind_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!kind && (align_init != '0))
                        state_next = ST_ALIGN;
                    else
                        state_next = ST_ACCUM;
                end
            end
            ST_ALIGN:
            begin
                if (align_reg == ridx_t'(1))
                    state_next = ST_ACCUM;
            end
            ST_ACCUM:
            begin
                if (step_reg == win_last)
                    state_next = ST_SLIDE;
            end
            ST_SLIDE:
            begin
                if (step_reg == ridx_t'(RESIDUE_MODULUS - 1))
                    state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        step_next  = step_reg;
        align_next = align_reg;
        kind_next  = kind_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    kind_next  = kind;
                    align_next = kind ? '0 : align_init;
                    step_next  = '0;
                end
            end
            ST_ALIGN:
            begin
                align_next = align_reg - ridx_t'(1);
            end
            ST_ACCUM:
            begin
                if (step_reg == win_last)
                    step_next = '0;
                else
                    step_next = step_reg + ridx_t'(1);
            end
            ST_SLIDE:
            begin
                step_next = step_reg + ridx_t'(1);
            end
            default:
            begin
                step_next = step_reg;
            end
        endcase
    end

    always_comb
    begin
        ctl         = '0;
        ctl.wild    = kind_reg;
        case (state_reg)
            ST_IDLE:
            begin
                ctl.load = accept;
            end
            ST_ALIGN:
            begin
                ctl.rotate = 1'b1;
            end
            ST_ACCUM:
            begin
                ctl.rotate = 1'b1;
                ctl.acc_en = 1'b1;
            end
            ST_SLIDE:
            begin
                ctl.rotate  = 1'b1;
                ctl.acc_en  = 1'b1;
                ctl.use_tap = 1'b1;
                ctl.push    = 1'b1;
            end
            ST_COMMIT:
            begin
                ctl.commit = 1'b1;
            end
            ST_EMIT:
            begin
                ctl.emit = out_free;
            end
            default:
            begin
                ctl.load = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/wildcard_digit_residue_counter.sv
// Top level of the wildcard digit residue counter: count registers and datapath.
// Depends on wdrc_pkg, wdrc_mod_unit and wdrc_ctrl.
//
// Input channel (in_valid/in_ready): one pattern symbol per transfer; kind 0 is a
// fixed digit, kind 1 a wildcard; first restarts the counts at the empty prefix.
// Output channel (out_valid/out_ready): one matching_count per symbol, the count
// mod 1000000007 of matching strings at the target remainder (0 if target >= 13).
// Config channel (cfg_valid/cfg_ready): writes target_residue; always ready.
// Symbols are processed one at a time. The counts are held in remainder order
// and pass through a rotating register that feeds the single modular unit:
// a wildcard runs through its window and slide steps; a digit first runs
// alignment steps, which a digit of residue zero skips, then window and
// slide steps. Commit and emit follow, and in_ready returns as the result
// is loaded into the output register.
// A stalled receiver holds the result in the output register; the block then
// waits in its emit step and takes no new symbol until the slot frees.
// Reset sets the counts to one string at remainder zero and the target to 5.

module wildcard_digit_residue_counter
    import wdrc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               kind,
    input  logic [DIGIT_W-1:0] digit,
    input  logic               first,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [CNT_W-1:0]   matching_count,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [TGT_W-1:0]   target_residue
);

    localparam int M = RESIDUE_MODULUS;

    ctl_t ctl;
    logic out_free;

    cnt_t v_reg  [M];
    cnt_t v_next [M];
    cnt_t sh_reg [M];
    cnt_t sh_next[M];
    cnt_t o_reg  [M];
    cnt_t o_next [M];
    cnt_t acc_reg, acc_next;

    logic [TGT_W-1:0] target_reg, target_next;
    logic             out_valid_reg, out_valid_next;
    cnt_t             count_out_reg, count_out_next;

    cnt_t unit_c;
    cnt_t unit_y;
    logic tgt_ok;

    assign cfg_ready      = 1'b1;
    assign out_free       = !out_valid_reg || out_ready;
    assign out_valid      = out_valid_reg;
    assign matching_count = count_out_reg;
    assign tgt_ok         = (int'(target_reg) < M);

    wdrc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .kind     (kind),
        .digit    (digit),
        .out_free (out_free),
        .in_ready (in_ready),
        .ctl      (ctl)
    );

    // Window tap: start of the 10-wide window for a wildcard, previous entry for a digit
    always_comb
    begin
        if (!ctl.use_tap)
            unit_c = '0;
        else if (ctl.wild)
            unit_c = sh_reg[M - WILD_DIGITS];
        else
            unit_c = sh_reg[M - 1];
    end

    wdrc_mod_unit u_mod (
        .a (acc_reg),
        .b (sh_reg[0]),
        .c (unit_c),
        .y (unit_y)
    );

    always_comb
    begin
        for (int s = 0; s < M; s++)
        begin
            if (ctl.load)
            begin
                if (first)
                    sh_next[s] = (s == 0) ? cnt_t'(1) : '0;
                else
                    sh_next[s] = v_reg[j_of_s(s)];
            end
            else if (ctl.rotate)
                sh_next[s] = sh_reg[(s + 1) % M];
            else
                sh_next[s] = sh_reg[s];
        end
    end

    always_comb
    begin
        if (ctl.load)
            acc_next = '0;
        else if (ctl.acc_en)
            acc_next = unit_y;
        else
            acc_next = acc_reg;
    end

    always_comb
    begin
        for (int i = 0; i < M; i++)
        begin
            if (ctl.push)
                o_next[i] = (i == M - 1) ? acc_reg : o_reg[(i + 1) % M];
            else
                o_next[i] = o_reg[i];
        end
    end

    // Wildcard results enter starting at remainder 9, digit results at remainder 0
    always_comb
    begin
        for (int r = 0; r < M; r++)
        begin
            if (ctl.commit)
                v_next[r] = ctl.wild ? o_reg[rot_src(r, WILD_DIGITS - 1)] : o_reg[r];
            else
                v_next[r] = v_reg[r];
        end
    end

    always_comb
    begin
        target_next    = cfg_valid ? target_residue : target_reg;
        out_valid_next = out_valid_reg;
        count_out_next = count_out_reg;
        if (ctl.emit)
        begin
            out_valid_next = 1'b1;
            count_out_next = tgt_ok ? v_reg[ridx_t'(target_reg)] : '0;
        end
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < M; r++)
            begin
                v_reg[r] <= (r == 0) ? cnt_t'(1) : '0;
            end
            target_reg    <= TARGET_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            for (int r = 0; r < M; r++)
            begin
                v_reg[r] <= v_next[r];
            end
            target_reg    <= target_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < M; i++)
        begin
            sh_reg[i] <= sh_next[i];
            o_reg[i]  <= o_next[i];
        end
        acc_reg       <= acc_next;
        count_out_reg <= count_out_next;
    end

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for wildcard_digit_residue_counter: directed table, then random
// symbol runs under several target settings, with sender and receiver stalls.
// Depends on wdrc_pkg and the RTL under rtl/.

module tb_top;
    import wdrc_pkg::*;

    localparam logic KIND_DIGIT     = 1'b0;
    localparam logic KIND_WILD      = 1'b1;
    localparam int   RAND_PHASES    = 5;
    localparam int   PHASE_ITEMS    = 250;
    localparam int   HOLD_PHASE     = 2;
    localparam int   LONG_HOLD      = 300;
    localparam int   WATCHDOG_LIMIT = 3000;
    localparam int   SETTLE_CYCLES  = 40;

    typedef enum logic {ROW_SYM, ROW_CFG} row_op_t;

    typedef struct packed {
        row_op_t            op;
        logic               kind;
        logic [DIGIT_W-1:0] digit;
        logic               first;
        logic [TGT_W-1:0]   tgt;
        bit                 typed;
        cnt_t               value;
    } row_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic               kind;
    logic [DIGIT_W-1:0] digit;
    logic               first;
    logic               out_valid;
    logic               out_ready;
    logic [CNT_W-1:0]   matching_count;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [TGT_W-1:0]   target_residue;

    cnt_t             residue_tally [RESIDUE_MODULUS];
    logic [TGT_W-1:0] target_sel;
    cnt_t             expected_counts [$];
    int               mismatches;
    int               quiet_cycles;
    bit               tx_bursts;
    bit               rx_bursts;
    bit               hold_req;

    row_t directed [21] = '{
        '{ROW_SYM, KIND_DIGIT, 4'd5,  1'b0, 4'd0,  1'b1, 30'd1},  // state after reset
        '{ROW_SYM, KIND_WILD,  4'd0,  1'b1, 4'd0,  1'b1, 30'd1},
        '{ROW_SYM, KIND_WILD,  4'd15, 1'b0, 4'd0,  1'b0, 30'd0},
        '{ROW_SYM, KIND_DIGIT, 4'd15, 1'b1, 4'd0,  1'b1, 30'd0},  // digit above nine
        '{ROW_SYM, KIND_DIGIT, 4'd9,  1'b0, 4'd0,  1'b0, 30'd0},
        '{ROW_CFG, KIND_DIGIT, 4'd0,  1'b0, 4'd0,  1'b0, 30'd0},
        '{ROW_SYM, KIND_DIGIT, 4'd0,  1'b1, 4'd0,  1'b1, 30'd1},
        '{ROW_SYM, KIND_DIGIT, 4'd13, 1'b1, 4'd0,  1'b1, 30'd1},
        '{ROW_SYM, KIND_WILD,  4'd10, 1'b0, 4'd0,  1'b0, 30'd0},
        '{ROW_CFG, KIND_DIGIT, 4'd0,  1'b0, 4'd12, 1'b0, 30'd0},
        '{ROW_SYM, KIND_DIGIT, 4'd12, 1'b1, 4'd0,  1'b1, 30'd1},
        '{ROW_SYM, KIND_WILD,  4'd3,  1'b0, 4'd0,  1'b0, 30'd0},
        '{ROW_SYM, KIND_WILD,  4'd0,  1'b0, 4'd0,  1'b0, 30'd0},
        '{ROW_SYM, KIND_DIGIT, 4'd14, 1'b0, 4'd0,  1'b0, 30'd0},
        '{ROW_CFG, KIND_DIGIT, 4'd0,  1'b0, 4'd15, 1'b0, 30'd0},  // target out of range
        '{ROW_SYM, KIND_WILD,  4'd0,  1'b1, 4'd0,  1'b1, 30'd0},
        '{ROW_SYM, KIND_DIGIT, 4'd7,  1'b0, 4'd0,  1'b1, 30'd0},
        '{ROW_CFG, KIND_DIGIT, 4'd0,  1'b0, 4'd13, 1'b0, 30'd0},
        '{ROW_SYM, KIND_WILD,  4'd0,  1'b0, 4'd0,  1'b1, 30'd0},
        '{ROW_CFG, KIND_DIGIT, 4'd0,  1'b0, 4'd14, 1'b0, 30'd0},
        '{ROW_SYM, KIND_DIGIT, 4'd11, 1'b1, 4'd0,  1'b1, 30'd0}
    };

    wildcard_digit_residue_counter uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .digit          (digit),
        .first          (first),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .matching_count (matching_count),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .target_residue (target_residue)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic void clear_tally();
        foreach (residue_tally[i])
            residue_tally[i] = '0;
        residue_tally[0] = cnt_t'(1);
    endfunction

    // Applies one symbol to the tally and returns the count at the selected remainder, or zero if it is out of range.
    function automatic cnt_t advance_tally(input logic k, input logic [DIGIT_W-1:0] dg,
                                           input logic f);
        cnt_t             nxt [RESIDUE_MODULUS];
        logic [SUM_W-1:0] s;
        int               j;
        int               d;
        int               r;
        if (f)
            clear_tally();
        foreach (nxt[i])
            nxt[i] = '0;
        for (j = 0; j < RESIDUE_MODULUS; j++)
        begin
            for (d = 0; d < WILD_DIGITS; d++)
            begin
                if (k == KIND_WILD || d == 0)
                begin
                    r = (j * DIGIT_BASE + ((k == KIND_WILD) ? d : int'(dg))) % RESIDUE_MODULUS;
                    s = SUM_W'(nxt[r]) + SUM_W'(residue_tally[j]);
                    nxt[r] = (s >= SUM_W'(COUNT_MOD)) ? cnt_t'(s - SUM_W'(COUNT_MOD)) : cnt_t'(s);
                end
            end
        end
        residue_tally = nxt;
        if (int'(target_sel) < RESIDUE_MODULUS)
            return residue_tally[target_sel];
        return '0;
    endfunction

    task automatic send_symbol(input logic k, input logic [DIGIT_W-1:0] dg, input logic f,
                               input bit typed, input cnt_t typed_val);
        cnt_t predicted;
        @(negedge clk);
        if (tx_bursts && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        digit    <= dg;
        first    <= f;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = advance_tally(k, dg, f);
        expected_counts = {expected_counts, (typed ? typed_val : predicted)};
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_counts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_target(input logic [TGT_W-1:0] v);
        drain_results();
        @(negedge clk);
        cfg_valid      <= 1'b1;
        target_residue <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        target_sel = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // receiver: short random stalls, plus one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                out_ready <= 1'b1;
            end
            else if (rx_bursts && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(negedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cnt_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_counts.size() == 0)
            begin
                mismatches++;
                $display("%0t: matching_count %0d transferred with nothing expected",
                         $time, matching_count);
            end
            else
            begin
                want = expected_counts.pop_front();
                if (matching_count !== want)
                begin
                    mismatches++;
                    $display("%0t: matching_count expected %0d actual %0d",
                             $time, want, matching_count);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        logic               k;
        logic [DIGIT_W-1:0] dg;
        logic               f;
        logic [TGT_W-1:0]   tgt;
        int                 p;
        int                 n;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        kind           = KIND_DIGIT;
        digit          = '0;
        first          = 1'b0;
        cfg_valid      = 1'b0;
        target_residue = '0;
        tx_bursts      = 1'b1;
        rx_bursts      = 1'b1;
        hold_req       = 1'b0;
        mismatches     = 0;
        quiet_cycles   = 0;
        clear_tally();
        target_sel = TARGET_RESET;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        foreach (directed[i])
        begin
            if (directed[i].op == ROW_CFG)
                write_target(directed[i].tgt);
            else
                send_symbol(directed[i].kind, directed[i].digit, directed[i].first,
                            directed[i].typed, directed[i].value);
        end

        for (p = 0; p < RAND_PHASES; p++)
        begin
            case (p)
                0:       tgt = '0;
                1:       tgt = TGT_W'(RESIDUE_MODULUS - 1);
                2:       tgt = TGT_W'($urandom_range(0, 15));
                default: tgt = TGT_W'($urandom_range(0, RESIDUE_MODULUS - 1));
            endcase
            write_target(tgt);
            if (p == HOLD_PHASE)
                hold_req = 1'b1;
            if (p == RAND_PHASES - 1)
            begin
                tx_bursts = 1'b0;
                rx_bursts = 1'b0;
            end
            // long runs between restarts so the counts wrap the modulus
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                k = logic'($urandom_range(0, 1));
                f = ($urandom_range(0, 39) == 0);
                if (k == KIND_WILD)
                    dg = DIGIT_W'($urandom_range(0, 15));
                else if ($urandom_range(0, 4) == 0)
                    dg = DIGIT_W'($urandom_range(10, 15));
                else
                    dg = DIGIT_W'($urandom_range(0, 9));
                send_symbol(k, dg, f, 1'b0, '0);
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> files.f
rtl/wdrc_pkg.sv
rtl/wdrc_mod_unit.sv
rtl/wdrc_ctrl.sv
rtl/wildcard_digit_residue_counter.sv
dv/tb_top.sv
